// ===== rtl/lcsd_pkg.sv =====
`default_nettype none

package lcsd_pkg;

    // Chip geometry and serial word format.
    localparam int LEDS_PER_CHIP  = 12;
    localparam int WORDS_PER_CHIP = LEDS_PER_CHIP + 1;
    localparam int WORD_BITS      = 16;
    localparam int LED_W          = 8;

    // Defaults for the top-level parameters.
    localparam int MAX_CHIPS_DEF        = 8;
    localparam int LATCH_WAIT_TICKS_DEF = 220;
    localparam int TAIL_WAIT_TICKS_DEF  = 1;

    // Last slot of a chip's word group and last step of the pulse train.
    localparam logic [3:0] SLOT_LAST  = 4'(LEDS_PER_CHIP);
    localparam logic [3:0] BIT_LAST   = 4'(WORD_BITS - 1);
    localparam logic [2:0] PULSE_LAST = 3'd7;

    // Command codes carried on the input stream.
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_TICK      = 3'd0;
    localparam t_cmd CMD_SET_ONE   = 3'd1;
    localparam t_cmd CMD_SET_ALL   = 3'd2;
    localparam t_cmd CMD_CLEAR_ALL = 3'd3;
    localparam t_cmd CMD_REFRESH   = 3'd4;

    // Register indexes on the configuration port.
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_LOW   = 3'd0;
    localparam t_reg_idx REG_HIGH  = 3'd1;
    localparam t_reg_idx REG_CMDW  = 3'd2;
    localparam t_reg_idx REG_AUTO  = 3'd3;
    localparam t_reg_idx REG_CHAIN = 3'd4;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND,
        PH_LATCH,
        PH_PULSE,
        PH_TAIL
    } t_phase;

    // Write request from the command decoder to the intensity store.
    typedef struct packed {
        logic             wr_one;
        logic             fill_all;
        logic [LED_W-1:0] value;
    } t_store_ctl;

    // One result transaction.
    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic clk_pin;
        logic data_pin;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lcsd_store.sv =====
`default_nettype none

module lcsd_store #(
    parameter int MAX_CHIPS = lcsd_pkg::MAX_CHIPS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  lcsd_pkg::t_store_ctl                    i_ctl,
    input  wire  [$clog2(MAX_CHIPS*12)-1:0]         i_wr_addr,
    input  wire  [$clog2(MAX_CHIPS+1)-1:0]          i_nchips,
    input  wire  [$clog2(MAX_CHIPS+1)-1:0]          i_rd_chip,
    input  wire  [3:0]                              i_rd_slot,
    output logic [7:0]                              o_rd_led
);
    import lcsd_pkg::*;

    localparam int DEPTH = MAX_CHIPS * LEDS_PER_CHIP;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int CHW   = $clog2(MAX_CHIPS + 1);
    localparam int CIW   = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

    logic [LED_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [LED_W-1:0] r_fill [MAX_CHIPS];

    logic [LED_W-1:0] r_rd_data;
    logic             r_rd_valid;
    logic [LED_W-1:0] r_rd_fill;

    logic [LW-1:0]    n_leds;
    logic             rd_ok;
    logic [LW-1:0]    rd_addr_w;
    logic [AW-1:0]    rd_addr;
    logic [CIW-1:0]   rd_fi;

    // LEDs covered by a set-all or clear-all.
    assign n_leds = LW'(i_nchips * LEDS_PER_CHIP);

    // Read address of the LED word selected by chip and slot.
    assign rd_ok     = (i_rd_chip < CHW'(MAX_CHIPS)) && (i_rd_slot != 4'd0)
                       && (i_rd_slot <= SLOT_LAST);
    assign rd_addr_w = LW'(i_rd_chip * LEDS_PER_CHIP) + LW'(i_rd_slot) - LW'(1);
    assign rd_addr   = rd_ok ? rd_addr_w[AW-1:0] : '0;
    assign rd_fi     = rd_ok ? i_rd_chip[CIW-1:0] : '0;

    // Intensity memory, one write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_one) begin
            mem[i_wr_addr] <= i_ctl.value;
        end
    end

    // Registered read of memory, valid bit and per-chip fill value.
    always_ff @(posedge i_clk) begin
        r_rd_data  <= mem[rd_addr];
        r_rd_valid <= r_valid[rd_addr];
        r_rd_fill  <= r_fill[rd_fi];
    end

    // An entry not written since the last fill reads as its chip's fill value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int c = 0; c < MAX_CHIPS; c++) begin
                r_fill[c] <= '0;
            end
        end else if (i_ctl.wr_one) begin
            r_valid[i_wr_addr] <= 1'b1;
        end else if (i_ctl.fill_all) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (LW'(i) < n_leds) begin
                    r_valid[i] <= 1'b0;
                end
            end
            for (int c = 0; c < MAX_CHIPS; c++) begin
                if (CHW'(c) < i_nchips) begin
                    r_fill[c] <= i_ctl.value;
                end
            end
        end
    end

    assign o_rd_led = r_rd_valid ? r_rd_data : r_rd_fill;

endmodule

`default_nettype wire

// ===== rtl/led_chain_serial_driver_unit.sv =====
`default_nettype none

// Channel     Dir  Transfer                    Contents
// s_axis      in   tvalid & tready             tuser: cmd; tdata: led_index, led_on
// m_axis      out  tvalid & tready             tdata: data_pin, clk_pin, busy_res, rejected
// apb         in   psel & penable & pwrite     five configuration registers, 4-byte stride
//
// One command transaction is taken per clock cycle while s_axis is not stalled; its
// result is registered and appears on m_axis from the result register.
// A two-entry output (result register plus skid register) keeps s_axis open while a
// result waits; s_axis stalls only when both entries are full.
// Reset is synchronous and active low; the intensity store reads as zero after reset
// through its valid bits, so no clearing pass is needed.

module led_chain_serial_driver_unit #(
    parameter int MAX_CHIPS        = lcsd_pkg::MAX_CHIPS_DEF,
    parameter int LATCH_WAIT_TICKS = lcsd_pkg::LATCH_WAIT_TICKS_DEF,
    parameter int TAIL_WAIT_TICKS  = lcsd_pkg::TAIL_WAIT_TICKS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [6:0] led_index, [7] led_on
    input  wire  [2:0]  i_s_axis_tuser,   // [2:0] cmd

    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] data_pin, [1] clk_pin, [2] busy_res,
                                          // [3] rejected, [7:4] zero

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcsd_pkg::*;

    localparam int DEPTH = MAX_CHIPS * LEDS_PER_CHIP;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int CHW   = $clog2(MAX_CHIPS + 1);
    localparam int NCW   = (CHW > 4) ? CHW : 4;
    localparam int XW    = (LW > 7) ? LW : 7;

    // Configuration registers.
    logic [7:0]  r_low;
    logic [7:0]  r_high;
    logic [15:0] r_cmdw;
    logic        r_auto;
    logic [3:0]  r_chain;
    logic        cfg_wr;

    // Sequencer state.
    t_phase          r_phase, n_phase, adv_phase;
    logic [CHW-1:0]  r_chip, n_chip, adv_chip, chip_inc;
    logic [3:0]      r_slot, n_slot, adv_slot;
    logic [3:0]      r_bit, n_bit, adv_bit;
    logic [7:0]      r_wait, n_wait, adv_wait, wait_inc;
    logic [2:0]      r_pulse, n_pulse, adv_pulse;
    logic            r_clk, n_clk, adv_clk;
    logic            r_data, n_data, adv_data;

    // Output buffering.
    logic            r_out_valid, r_skid_valid;
    t_result         r_out_res, r_skid_res, res;
    logic            out_take;

    // Command decode.
    logic            accept;
    t_cmd            cmd;
    logic [6:0]      in_index;
    logic            in_on;
    logic            is_cmd;
    logic            busy;
    logic            rej;
    t_store_ctl      ctl;
    logic [NCW-1:0]  chain_w;
    logic [CHW-1:0]  nchips;
    logic [LW-1:0]   n_leds;
    logic [XW-1:0]   idx_w;
    logic [XW-1:0]   idx_last;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      rd_led;
    logic            send_bit;

    assign cmd      = i_s_axis_tuser;
    assign in_index = i_s_axis_tdata[6:0];
    assign in_on    = i_s_axis_tdata[7];
    assign accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign busy     = (r_phase != PH_IDLE);
    assign is_cmd   = (cmd >= CMD_SET_ONE) && (cmd <= CMD_REFRESH);

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= 8'd0;
            r_high  <= 8'hff;
            r_cmdw  <= 16'd0;
            r_auto  <= 1'b1;
            r_chain <= 4'd1;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_LOW:   r_low   <= pwdata[7:0];
                REG_HIGH:  r_high  <= pwdata[7:0];
                REG_CMDW:  r_cmdw  <= pwdata[15:0];
                REG_AUTO:  r_auto  <= pwdata[0];
                REG_CHAIN: r_chain <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LOW:   prdata = {24'd0, r_low};
            REG_HIGH:  prdata = {24'd0, r_high};
            REG_CMDW:  prdata = {16'd0, r_cmdw};
            REG_AUTO:  prdata = {31'd0, r_auto};
            REG_CHAIN: prdata = {28'd0, r_chain};
            default:   prdata = 32'd0;
        endcase
    end

    // Chips in use, with zero taken as one and the top clamped to the maximum.
    always_comb begin
        chain_w = NCW'(r_chain);
        if (chain_w == '0) begin
            chain_w = NCW'(1);
        end else if (chain_w > NCW'(MAX_CHIPS)) begin
            chain_w = NCW'(MAX_CHIPS);
        end
    end
    assign nchips = chain_w[CHW-1:0];
    assign n_leds = LW'(nchips * LEDS_PER_CHIP);

    // Set-one index clamped to the last LED in use.
    assign idx_last = XW'(n_leds - LW'(1));
    always_comb begin
        idx_w = XW'(in_index);
        if (idx_w > idx_last) begin
            idx_w = idx_last;
        end
    end
    assign wr_addr = idx_w[AW-1:0];

    // Intensity store; read follows the word being shifted.
    lcsd_store #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_wr_addr (wr_addr),
        .i_nchips  (nchips),
        .i_rd_chip (r_chip),
        .i_rd_slot (r_slot),
        .o_rd_led  (rd_led)
    );

    // Current serial bit: command word in slot zero, else eight zeros then the LED byte.
    assign send_bit = (r_slot == 4'd0) ? r_cmdw[~r_bit]
                                       : (r_bit[3] & rd_led[~r_bit[2:0]]);
    assign chip_inc = (r_slot == SLOT_LAST) ? (r_chip + CHW'(1)) : r_chip;
    assign wait_inc = r_wait + 8'd1;

    // One step of the refresh and latch sequence.
    always_comb begin
        adv_phase = r_phase;
        adv_chip  = r_chip;
        adv_slot  = r_slot;
        adv_bit   = r_bit;
        adv_wait  = r_wait;
        adv_pulse = r_pulse;
        adv_clk   = r_clk;
        adv_data  = r_data;
        case (r_phase)
            PH_SEND: begin
                adv_data = send_bit;
                adv_clk  = ~r_clk;
                adv_bit  = r_bit + 4'd1;
                if (r_bit == BIT_LAST) begin
                    adv_chip = chip_inc;
                    adv_slot = (r_slot == SLOT_LAST) ? 4'd0 : (r_slot + 4'd1);
                    if (chip_inc >= nchips) begin
                        adv_phase = PH_LATCH;
                        adv_wait  = 8'd0;
                    end
                end
            end
            PH_LATCH: begin
                adv_data = 1'b0;
                adv_wait = wait_inc;
                if (wait_inc >= 8'(LATCH_WAIT_TICKS)) begin
                    adv_phase = PH_PULSE;
                    adv_pulse = 3'd0;
                end
            end
            PH_PULSE: begin
                adv_data = ~r_pulse[0];
                if (r_pulse >= PULSE_LAST) begin
                    adv_pulse = 3'd0;
                    adv_phase = PH_TAIL;
                    adv_wait  = 8'd0;
                end else begin
                    adv_pulse = r_pulse + 3'd1;
                end
            end
            PH_TAIL: begin
                adv_data = 1'b0;
                adv_wait = wait_inc;
                if (wait_inc >= 8'(TAIL_WAIT_TICKS)) begin
                    adv_phase = PH_IDLE;
                    adv_wait  = 8'd0;
                end
            end
            default: begin
                adv_phase = PH_IDLE;
            end
        endcase
    end

    // Command handling for an accepted transaction.
    always_comb begin
        n_phase = r_phase;
        n_chip  = r_chip;
        n_slot  = r_slot;
        n_bit   = r_bit;
        n_wait  = r_wait;
        n_pulse = r_pulse;
        n_clk   = r_clk;
        n_data  = r_data;
        rej     = 1'b0;
        ctl     = '0;
        if (accept) begin
            if (!is_cmd || busy) begin
                rej     = is_cmd;
                n_phase = adv_phase;
                n_chip  = adv_chip;
                n_slot  = adv_slot;
                n_bit   = adv_bit;
                n_wait  = adv_wait;
                n_pulse = adv_pulse;
                n_clk   = adv_clk;
                n_data  = adv_data;
            end else begin
                if (cmd == CMD_SET_ONE) begin
                    ctl.wr_one = 1'b1;
                    ctl.value  = in_on ? r_high : r_low;
                end else if (cmd != CMD_REFRESH) begin
                    ctl.fill_all = 1'b1;
                    ctl.value    = (cmd == CMD_SET_ALL) ? r_high : r_low;
                end
                if ((cmd == CMD_REFRESH) || r_auto) begin
                    n_phase = PH_SEND;
                    n_chip  = '0;
                    n_slot  = 4'd0;
                    n_bit   = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_chip  <= '0;
            r_slot  <= 4'd0;
            r_bit   <= 4'd0;
            r_wait  <= 8'd0;
            r_pulse <= 3'd0;
            r_clk   <= 1'b0;
            r_data  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_chip  <= n_chip;
            r_slot  <= n_slot;
            r_bit   <= n_bit;
            r_wait  <= n_wait;
            r_pulse <= n_pulse;
            r_clk   <= n_clk;
            r_data  <= n_data;
        end
    end

    // Result of the accepted transaction, taken from the updated line state.
    assign res = '{rejected: rej, busy_res: (n_phase != PH_IDLE),
                   clk_pin: n_clk, data_pin: n_data};

    // Result register with a skid stage behind it.
    assign out_take        = r_out_valid & i_m_axis_tready;
    assign o_s_axis_tready = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid | accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out_res <= r_skid_valid ? r_skid_res : res;
        end else if (accept) begin
            r_skid_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_res};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lcsd_pkg::*;

    localparam int STORE_DEPTH  = MAX_CHIPS_DEF * LEDS_PER_CHIP;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_REPORTS  = 20;

    // Command codes the block treats as plain ticks.
    localparam t_cmd CMD_SPARE_5 = 3'd5;
    localparam t_cmd CMD_SPARE_6 = 3'd6;
    localparam t_cmd CMD_SPARE_7 = 3'd7;

    // Receiver back-pressure patterns.
    localparam int RDY_OPEN   = 0;
    localparam int RDY_RANDOM = 1;
    localparam int RDY_SPARSE = 2;

    // Clock, reset and the ports of the block.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = '0;    // [6:0] led_index, [7] led_on
    logic [2:0]  s_tuser = '0;    // [2:0] cmd

    wire         m_tvalid;
    logic        m_tready = 1'b1;
    wire  [7:0]  m_tdata;         // [0] data_pin, [1] clk_pin, [2] busy_res, [3] rejected

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    led_chain_serial_driver_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mirror of the configuration registers.
    logic [7:0]  cfg_low      = 8'd0;
    logic [7:0]  cfg_high     = 8'd255;
    logic [15:0] cfg_cmd_word = 16'd0;
    logic        cfg_auto     = 1'b1;
    logic [3:0]  cfg_chain    = 4'd1;

    // Mirror of the sequencer and the intensity store.
    logic [7:0]  led_level [STORE_DEPTH];
    t_phase      seq_phase  = PH_IDLE;
    logic        line_clk   = 1'b0;
    logic        line_data  = 1'b0;
    int          word_pos   = 0;
    int          bit_pos    = 0;
    int          hold_count = 0;
    int          pulse_step = 0;

    t_result     pending_results [$];

    int          err_count        = 0;
    int          items_sent       = 0;
    int          results_checked  = 0;
    int          reg_writes       = 0;
    int          refreshes_started = 0;
    int          rejects_predicted = 0;

    // One row of the directed stimulus.
    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;
    typedef struct {
        t_row_kind   kind;
        t_cmd        cmd;
        t_reg_idx    sel;
        logic [31:0] value;   // LED index for an item, register value for a write
        logic        on;
        logic        typed;   // use the written-out result below
        t_result     want;    // {rejected, busy_res, clk_pin, data_pin}
    } t_row;

    localparam int DIR_ROWS = 30;

    // Register writes in the middle of a refresh are part of this table on purpose.
    t_row dir_table [DIR_ROWS] = '{
        '{ROW_ITEM,  CMD_TICK,      REG_LOW,   32'd0,      1'b0, 1'b1, 4'b0000},
        '{ROW_ITEM,  CMD_SPARE_7,   REG_LOW,   32'd127,    1'b1, 1'b1, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_AUTO,  32'd0,      1'b0, 1'b0, 4'b0000},
        '{ROW_ITEM,  CMD_SET_ONE,   REG_LOW,   32'd0,      1'b1, 1'b1, 4'b0000},
        '{ROW_ITEM,  CMD_SET_ONE,   REG_LOW,   32'd127,    1'b0, 1'b1, 4'b0000},
        '{ROW_ITEM,  CMD_SPARE_5,   REG_LOW,   32'd85,     1'b1, 1'b1, 4'b0000},
        '{ROW_ITEM,  CMD_SPARE_6,   REG_LOW,   32'd42,     1'b0, 1'b1, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_CHAIN, 32'd0,      1'b0, 1'b0, 4'b0000},
        '{ROW_ITEM,  CMD_SET_ALL,   REG_LOW,   32'd0,      1'b0, 1'b1, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_CHAIN, 32'd15,     1'b0, 1'b0, 4'b0000},
        '{ROW_ITEM,  CMD_CLEAR_ALL, REG_LOW,   32'd0,      1'b0, 1'b1, 4'b0000},
        '{ROW_ITEM,  CMD_SET_ONE,   REG_LOW,   32'd127,    1'b1, 1'b1, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_LOW,   32'd255,    1'b0, 1'b0, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_HIGH,  32'd0,      1'b0, 1'b0, 4'b0000},
        '{ROW_ITEM,  CMD_SET_ONE,   REG_LOW,   32'd50,     1'b1, 1'b1, 4'b0000},
        '{ROW_ITEM,  CMD_SET_ONE,   REG_LOW,   32'd60,     1'b0, 1'b1, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_CMDW,  32'hffff,   1'b0, 1'b0, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_CHAIN, 32'd1,      1'b0, 1'b0, 4'b0000},
        '{ROW_ITEM,  CMD_REFRESH,   REG_LOW,   32'd0,      1'b0, 1'b1, 4'b0100},
        '{ROW_ITEM,  CMD_TICK,      REG_LOW,   32'd0,      1'b0, 1'b1, 4'b0111},
        '{ROW_ITEM,  CMD_SET_ONE,   REG_LOW,   32'd3,      1'b1, 1'b1, 4'b1101},
        '{ROW_ITEM,  CMD_SET_ALL,   REG_LOW,   32'd0,      1'b0, 1'b1, 4'b1111},
        '{ROW_ITEM,  CMD_CLEAR_ALL, REG_LOW,   32'd0,      1'b0, 1'b1, 4'b1101},
        '{ROW_ITEM,  CMD_REFRESH,   REG_LOW,   32'd0,      1'b0, 1'b1, 4'b1111},
        '{ROW_WRITE, CMD_TICK,      REG_CHAIN, 32'd8,      1'b0, 1'b0, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_AUTO,  32'd1,      1'b0, 1'b0, 4'b0000},
        '{ROW_ITEM,  CMD_TICK,      REG_LOW,   32'd0,      1'b0, 1'b0, 4'b0000},
        '{ROW_WRITE, CMD_TICK,      REG_CMDW,  32'd0,      1'b0, 1'b0, 4'b0000},
        '{ROW_ITEM,  CMD_TICK,      REG_LOW,   32'd0,      1'b0, 1'b0, 4'b0000},
        '{ROW_ITEM,  CMD_SPARE_7,   REG_LOW,   32'd0,      1'b0, 1'b0, 4'b0000}
    };

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_REPORTS) begin
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    // Number of chips in use, with out-of-range settings folded into range.
    function automatic int active_chips();
        int c;
        c = cfg_chain;
        if (c < 1) c = 1;
        if (c > MAX_CHIPS_DEF) c = MAX_CHIPS_DEF;
        return c;
    endfunction

    // Word being shifted out: the command word opens each chip's group.
    function automatic logic [15:0] shift_word();
        int chip;
        int slot;
        int k;
        chip = word_pos / WORDS_PER_CHIP;
        slot = word_pos % WORDS_PER_CHIP;
        if (slot == 0) return cfg_cmd_word;
        k = chip * LEDS_PER_CHIP + slot - 1;
        if (k >= STORE_DEPTH) return 16'h0000;
        return {8'h00, led_level[k]};
    endfunction

    task automatic begin_refresh();
        seq_phase = PH_SEND;
        word_pos  = 0;
        bit_pos   = 0;
        refreshes_started++;
    endtask

    // One step of the serial sequence.
    task automatic step_sequencer();
        logic [15:0] w;
        case (seq_phase)
            PH_SEND: begin
                w = shift_word();
                line_data = w[15 - bit_pos];
                line_clk  = ~line_clk;
                bit_pos++;
                if (bit_pos >= WORD_BITS) begin
                    bit_pos = 0;
                    word_pos++;
                    if (word_pos >= active_chips() * WORDS_PER_CHIP) begin
                        seq_phase  = PH_LATCH;
                        hold_count = 0;
                    end
                end
            end
            PH_LATCH: begin
                line_data = 1'b0;
                hold_count++;
                if (hold_count >= LATCH_WAIT_TICKS_DEF) begin
                    seq_phase  = PH_PULSE;
                    pulse_step = 0;
                end
            end
            PH_PULSE: begin
                line_data = (pulse_step % 2 == 1) ? 1'b0 : 1'b1;
                if (pulse_step >= int'(PULSE_LAST)) begin
                    pulse_step = 0;
                    seq_phase  = PH_TAIL;
                    hold_count = 0;
                end else begin
                    pulse_step++;
                end
            end
            PH_TAIL: begin
                line_data = 1'b0;
                hold_count++;
                if (hold_count >= TAIL_WAIT_TICKS_DEF) begin
                    seq_phase  = PH_IDLE;
                    hold_count = 0;
                end
            end
            default: seq_phase = PH_IDLE;
        endcase
    endtask

    // Predicts the result of one accepted command and updates the mirror.
    task automatic predict_step(input t_cmd c, input logic [6:0] idx, input logic on,
                                output t_result r);
        int n;
        int k;
        logic [7:0] v;
        r = '0;
        n = active_chips() * LEDS_PER_CHIP;
        if (c >= CMD_SET_ONE && c <= CMD_REFRESH) begin
            if (seq_phase != PH_IDLE) begin
                r.rejected = 1'b1;
                rejects_predicted++;
                step_sequencer();
            end else if (c == CMD_REFRESH) begin
                begin_refresh();
            end else begin
                if (c == CMD_SET_ONE) begin
                    k = idx;
                    if (k > n - 1) k = n - 1;
                    led_level[k] = on ? cfg_high : cfg_low;
                end else begin
                    v = (c == CMD_SET_ALL) ? cfg_high : cfg_low;
                    for (int i = 0; i < n; i++) led_level[i] = v;
                end
                if (cfg_auto) begin_refresh();
            end
        end else begin
            step_sequencer();
        end
        r.data_pin = line_data;
        r.clk_pin  = line_clk;
        r.busy_res = (seq_phase != PH_IDLE);
    endtask

    // Offers one command and waits for the transaction; returns the prediction.
    task automatic send_item(input t_cmd c, input logic [6:0] idx, input logic on,
                             output t_result predicted);
        s_tuser  <= c;
        s_tdata  <= {on, idx};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_step(c, idx, on, predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Writes one register, then reads it back.
    task automatic write_register(input t_reg_idx sel, input logic [31:0] value);
        logic [31:0] want;
        paddr   <= 5'({sel, 2'b00});
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (sel)
            REG_LOW:   cfg_low      = value[7:0];
            REG_HIGH:  cfg_high     = value[7:0];
            REG_CMDW:  cfg_cmd_word = value[15:0];
            REG_AUTO:  cfg_auto     = value[0];
            REG_CHAIN: cfg_chain    = value[3:0];
            default: ;
        endcase
        reg_writes++;
        case (sel)
            REG_LOW:   want = 32'(cfg_low);
            REG_HIGH:  want = 32'(cfg_high);
            REG_CMDW:  want = 32'(cfg_cmd_word);
            REG_AUTO:  want = 32'(cfg_auto);
            default:   want = 32'(cfg_chain);
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver back-pressure: a pattern, chosen at random, that changes after each stretch of random length.
    int         stall_left = 0;
    int         stall_mode = RDY_OPEN;
    logic [1:0] rdy_phase  = 2'd0;

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(RDY_OPEN, RDY_SPARSE);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        rdy_phase++;
        case (stall_mode)
            RDY_OPEN:   m_tready <= 1'b1;
            RDY_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
            default:    m_tready <= (rdy_phase == 2'd0);
        endcase
    end

    // Result checker: each result transaction against the oldest prediction.
    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[3:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(got), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.data_pin !== want.data_pin)
                    report_mismatch("data_pin", 32'(got.data_pin), 32'(want.data_pin));
                if (got.clk_pin !== want.clk_pin)
                    report_mismatch("clk_pin", 32'(got.clk_pin), 32'(want.clk_pin));
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                if (got.rejected !== want.rejected)
                    report_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
                results_checked++;
            end
        end
    end

    // Stimulus: directed table, then random phases with fresh settings.
    initial begin : stimulus
        t_result predicted;
        t_cmd    c;
        int      pick;
        int      rand_left;
        int      phase_len;
        int      burst_left;
        int      gap;

        foreach (led_level[i]) led_level[i] = 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_WRITE) begin
                drain_results();
                write_register(dir_table[r].sel, dir_table[r].value);
            end else begin
                send_item(dir_table[r].cmd, dir_table[r].value[6:0], dir_table[r].on,
                          predicted);
                pending_results.push_back(dir_table[r].typed ? dir_table[r].want
                                                             : predicted);
            end
        end
        drain_results();

        rand_left  = RANDOM_ITEMS;
        burst_left = 0;
        while (rand_left > 0) begin
            // New settings while no transaction is outstanding; a refresh may be under way.
            if ($urandom_range(0, 1)) begin
                pick = $urandom_range(0, 3);
                write_register(REG_LOW, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd255
                                                    : 32'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1)) begin
                pick = $urandom_range(0, 3);
                write_register(REG_HIGH, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd255
                                                     : 32'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1)) begin
                pick = $urandom_range(0, 3);
                write_register(REG_CMDW, (pick == 0) ? 32'd0 : (pick == 1) ? 32'hffff
                                                     : 32'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 1)) begin
                write_register(REG_AUTO, ($urandom_range(0, 9) < 8) ? 32'd1 : 32'd0);
            end
            if ($urandom_range(0, 1)) begin
                // Mostly one chip so that refreshes stay short.
                pick = $urandom_range(0, 99);
                if (pick < 60)      write_register(REG_CHAIN, 32'd1);
                else if (pick < 75) write_register(REG_CHAIN, 32'd0);
                else if (pick < 90) write_register(REG_CHAIN, 32'($urandom_range(2, 3)));
                else                write_register(REG_CHAIN, 32'($urandom_range(4, 15)));
            end

            phase_len = $urandom_range(20, 200);
            for (int k = 0; k < phase_len && rand_left > 0; k++) begin
                // Sender bursts and gaps; now and then a long stretch without gaps.
                if (burst_left == 0) begin
                    if ($urandom_range(0, 4) == 0) begin
                        burst_left = $urandom_range(100, 200);
                        gap = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap = $urandom_range(0, 7);
                    end
                    if (gap != 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;

                // Mostly ticks while busy, mostly commands while idle.
                pick = $urandom_range(0, 99);
                if (seq_phase == PH_IDLE) begin
                    if (pick < 30)      c = CMD_SET_ONE;
                    else if (pick < 45) c = CMD_SET_ALL;
                    else if (pick < 55) c = CMD_CLEAR_ALL;
                    else if (pick < 80) c = CMD_REFRESH;
                    else if (pick < 92) c = CMD_TICK;
                    else                c = t_cmd'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
                end else begin
                    if (pick < 90)      c = CMD_TICK;
                    else if (pick < 94) c = t_cmd'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
                    else                c = t_cmd'($urandom_range(CMD_SET_ONE, CMD_REFRESH));
                end
                send_item(c, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                          predicted);
                pending_results.push_back(predicted);
                rand_left--;
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d commands, %0d results checked, %0d register writes",
                 items_sent, results_checked, reg_writes);
        $display("refreshes started %0d, rejected commands %0d, mismatches %0d",
                 refreshes_started, rejects_predicted, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial begin : watchdog
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/lcsd_pkg.sv
rtl/lcsd_store.sv
rtl/led_chain_serial_driver_unit.sv
bench/tb_top.sv
